/* rtl/core/tcpq_pkg.sv */
// Shared types and codes for the two-class priority queue.
`default_nettype none

package tcpq_pkg;

  // Request operation codes
  localparam logic [2:0] OP_ADD_NORMAL = 3'd0;
  localparam logic [2:0] OP_ADD_URGENT = 3'd1;
  localparam logic [2:0] OP_SERVE      = 3'd2;
  localparam logic [2:0] OP_PEEK       = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;
  localparam logic [2:0] OP_DELETE     = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned REPORT_TOKEN_W = 16;

  // Entry payload except the token
  typedef struct packed {
    logic [31:0] handle;
    logic [7:0]  age;
    logic [1:0]  gender;
    logic        urgent;
  } info_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_RD0,
    S_CAP,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/tcpq_mem.sv */
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module tcpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned W     = 59
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/two_class_priority_queue.sv */
// Top level of the two-class priority queue: sequencer, counters and result register.
//
// - Request channel (in_valid / in_ready) carries op, record_handle, age, gender and
//   token_query. Take one request at a time; in_ready is high only while the
//   sequencer is idle.
// - Result channel (out_valid / out_ready) returns exactly one result per request from
//   an output register, so a new request is taken while an older result still waits.
// - Configuration channel (cfg_valid / cfg_ready) loads first_token into the token
//   counter; cfg_ready is high only while the sequencer is idle.
// - Requests walk the entries through the memory port, one memory access per cycle: an
//   add moves the entries behind the insert slot back, a serve closes the gap at the
//   front, a find or delete reads from the front until a match or the last entry held,
//   and a delete then closes the gap at the match. The sequencer is idle again in the
//   same cycle that the result turns valid.
// - Reset clears the entry count, the urgent count and the output valid and loads the
//   token counter with 100. Entry memory is not cleared; slots at or past the count
//   are never read.
// - When the receiver stalls, the result holds and the next request waits in its
//   final step until the output register frees.
`default_nettype none

module two_class_priority_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned TOKEN_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] record_handle,
  input  wire logic [7:0]  age,
  input  wire logic [1:0]  gender,
  input  wire logic [15:0] token_query,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      token,
  output logic [31:0]      record_handle_out,
  output logic [7:0]       age_out,
  output logic [1:0]       gender_out,
  output logic             urgent_out,
  output logic [6:0]       occupancy,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] first_token
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned INFO_W = $bits(tcpq_pkg::info_t);
  localparam int unsigned EW     = TOKEN_BITS + INFO_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);
  localparam logic [CW-1:0] ZERO_C  = CW'(0);

  // Sequencer state
  tcpq_pkg::state_t state, state_next;

  // Queue bookkeeping
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         ucount, ucount_next;
  logic [TOKEN_BITS-1:0] next_tok, next_tok_next;

  // Walk unit: index, insert position, pending write address
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [AW-1:0] wa, wa_next;
  logic          pend, pend_next;

  // Captured request
  logic [2:0]            c_op;
  logic [31:0]           c_handle;
  logic [7:0]            c_age;
  logic [1:0]            c_gender;
  logic [TOKEN_BITS-1:0] c_query;

  // Staged result
  logic [1:0]                            r_status, r_status_next;
  logic [tcpq_pkg::REPORT_TOKEN_W-1:0]   r_tok, r_tok_next;
  tcpq_pkg::info_t                       r_info, r_info_next;

  // Memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic [TOKEN_BITS-1:0] rd_tok;
  tcpq_pkg::info_t       rd_info;
  tcpq_pkg::info_t       new_info;
  logic                  is_add;
  logic                  add_urgent;
  logic                  scan_hit;
  logic                  up_more;
  logic                  down_more;
  logic                  out_free;
  logic                  in_take;

  assign rd_tok     = mem_rdata[EW-1 -: TOKEN_BITS];
  assign rd_info    = tcpq_pkg::info_t'(mem_rdata[INFO_W-1:0]);
  assign add_urgent = (c_op == tcpq_pkg::OP_ADD_URGENT);
  assign is_add     = (c_op == tcpq_pkg::OP_ADD_NORMAL) || add_urgent;
  assign new_info   = '{handle: c_handle, age: c_age, gender: c_gender, urgent: add_urgent};
  assign scan_hit   = pend && (rd_tok == c_query);
  assign up_more    = (idx > pos);
  assign down_more  = ((idx + ONE_C) < count);
  assign out_free   = !out_valid || out_ready;
  assign in_take    = in_valid && in_ready;

  assign in_ready  = (state == tcpq_pkg::S_IDLE);
  assign cfg_ready = (state == tcpq_pkg::S_IDLE);

  tcpq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcpq_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = tcpq_pkg::S_DECODE;
        end
      end
      tcpq_pkg::S_DECODE: begin
        if (is_add) begin
          state_next = (count == DEPTH_C) ? tcpq_pkg::S_FIN : tcpq_pkg::S_UP;
        end else if (c_op == tcpq_pkg::OP_SERVE) begin
          state_next = (count == ZERO_C) ? tcpq_pkg::S_FIN : tcpq_pkg::S_DOWN;
        end else if (c_op == tcpq_pkg::OP_PEEK) begin
          state_next = (count >= TWO_C) ? tcpq_pkg::S_CAP : tcpq_pkg::S_FIN;
        end else if ((c_op == tcpq_pkg::OP_FIND) || (c_op == tcpq_pkg::OP_DELETE)) begin
          state_next = tcpq_pkg::S_SCAN;
        end else begin
          state_next = tcpq_pkg::S_FIN;
        end
      end
      tcpq_pkg::S_UP: begin
        if (!up_more) begin
          state_next = tcpq_pkg::S_PUT;
        end
      end
      tcpq_pkg::S_PUT: begin
        state_next = tcpq_pkg::S_FIN;
      end
      tcpq_pkg::S_DOWN: begin
        if (!down_more) begin
          if ((c_op == tcpq_pkg::OP_SERVE) && (count != ONE_C)) begin
            state_next = tcpq_pkg::S_RD0;
          end else begin
            state_next = tcpq_pkg::S_FIN;
          end
        end
      end
      tcpq_pkg::S_RD0: begin
        state_next = tcpq_pkg::S_CAP;
      end
      tcpq_pkg::S_CAP: begin
        state_next = tcpq_pkg::S_FIN;
      end
      tcpq_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_next = (c_op == tcpq_pkg::OP_DELETE) ? tcpq_pkg::S_DOWN : tcpq_pkg::S_FIN;
        end else if (idx >= count) begin
          state_next = tcpq_pkg::S_FIN;
        end
      end
      tcpq_pkg::S_FIN: begin
        if (out_free) begin
          state_next = tcpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcpq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_next    = count;
    ucount_next   = ucount;
    next_tok_next = next_tok;
    idx_next      = idx;
    pos_next      = pos;
    wa_next       = wa;
    pend_next     = pend;
    r_status_next = r_status;
    r_tok_next    = r_tok;
    r_info_next   = r_info;
    mem_we        = 1'b0;
    mem_waddr     = wa;
    mem_wdata     = mem_rdata;
    mem_raddr     = '0;

    case (state)
      tcpq_pkg::S_DECODE: begin
        // Default result: miss, nothing reported
        r_status_next = tcpq_pkg::ST_MISS;
        r_tok_next    = '0;
        r_info_next   = '0;
        idx_next      = ZERO_C;
        pend_next     = 1'b0;
        if (is_add) begin
          if (count == DEPTH_C) begin
            r_status_next = tcpq_pkg::ST_FULL;
          end else begin
            // Walk from the back down to the insert slot
            pos_next = add_urgent ? ucount : count;
            idx_next = count;
          end
        end else if (c_op == tcpq_pkg::OP_SERVE) begin
          // The front is urgent whenever any urgent entry is held
          if (count != ZERO_C && ucount != ZERO_C) begin
            ucount_next = ucount - ONE_C;
          end
        end else if (c_op == tcpq_pkg::OP_PEEK) begin
          mem_raddr = AW'(1);
        end
      end
      tcpq_pkg::S_UP: begin
        // Move entry idx-1 to idx, one per cycle; each write follows its read in the next cycle
        mem_we = pend;
        if (up_more) begin
          mem_raddr = AW'(idx - ONE_C);
          wa_next   = AW'(idx);
          idx_next  = idx - ONE_C;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      tcpq_pkg::S_PUT: begin
        mem_we        = 1'b1;
        mem_waddr     = AW'(pos);
        mem_wdata     = {next_tok, new_info};
        r_status_next = tcpq_pkg::ST_OK;
        r_tok_next    = tcpq_pkg::REPORT_TOKEN_W'(next_tok);
        r_info_next   = new_info;
        count_next    = count + ONE_C;
        if (add_urgent) begin
          ucount_next = ucount + ONE_C;
        end
        next_tok_next = next_tok + TOKEN_BITS'(1);
      end
      tcpq_pkg::S_DOWN: begin
        // Move entry idx+1 to idx to close the gap
        mem_we = pend;
        if (down_more) begin
          mem_raddr = AW'(idx + ONE_C);
          wa_next   = AW'(idx);
          idx_next  = idx + ONE_C;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          count_next = count - ONE_C;
        end
      end
      tcpq_pkg::S_RD0: begin
        mem_raddr = '0;
      end
      tcpq_pkg::S_CAP: begin
        r_status_next = tcpq_pkg::ST_OK;
        r_tok_next    = tcpq_pkg::REPORT_TOKEN_W'(rd_tok);
        r_info_next   = rd_info;
      end
      tcpq_pkg::S_SCAN: begin
        if (scan_hit) begin
          r_status_next = tcpq_pkg::ST_OK;
          r_tok_next    = tcpq_pkg::REPORT_TOKEN_W'(rd_tok);
          r_info_next   = rd_info;
          pend_next     = 1'b0;
          if (c_op == tcpq_pkg::OP_DELETE) begin
            if (rd_info.urgent && (ucount != ZERO_C)) begin
              ucount_next = ucount - ONE_C;
            end
            idx_next = CW'(wa);
          end
        end else if (idx < count) begin
          // Read the next slot, compare it next cycle
          mem_raddr = AW'(idx);
          wa_next   = AW'(idx);
          idx_next  = idx + ONE_C;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // A config write reloads the token counter; it only lands while idle
    if (cfg_valid && cfg_ready && (state == tcpq_pkg::S_IDLE)) begin
      next_tok_next = TOKEN_BITS'(first_token);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcpq_pkg::S_IDLE;
      count     <= ZERO_C;
      ucount    <= ZERO_C;
      next_tok  <= TOKEN_BITS'(100);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ucount   <= ucount_next;
      next_tok <= next_tok_next;
      pend     <= pend_next;
      if ((state == tcpq_pkg::S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pos      <= pos_next;
    wa       <= wa_next;
    r_status <= r_status_next;
    r_tok    <= r_tok_next;
    r_info   <= r_info_next;
    if (in_take) begin
      c_op     <= op;
      c_handle <= record_handle;
      c_age    <= age;
      c_gender <= gender;
      c_query  <= TOKEN_BITS'(token_query);
    end
    // Hand the staged result to the output register once it is free
    if ((state == tcpq_pkg::S_FIN) && out_free) begin
      status            <= r_status;
      token             <= r_tok;
      record_handle_out <= r_info.handle;
      age_out           <= r_info.age;
      gender_out        <= r_info.gender;
      urgent_out        <= r_info.urgent;
      occupancy         <= 7'(count);
    end
  end

endmodule

`default_nettype wire
